@@ src/bole_pkg.sv @@
// Shared types and constants for the bounded ordered list engine.
// Used by bole_cell, bole_ctrl and bounded_ordered_list_engine_top.
package bole_pkg;

  localparam int CAPACITY  = 16;
  localparam int DATA_W    = 32;
  localparam int CNT_W     = 5;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int LIMIT_W   = 5;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(10);

  typedef enum logic [2:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_END   = 3'd1,
    CMD_INS_AFTER = 3'd2,
    CMD_DELETE    = 3'd3,
    CMD_SORT      = 3'd4,
    CMD_DUMP      = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE,
    OP_ROTATE,
    OP_COMPARE,
    OP_SORT
  } cell_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_FIND,
    S_SORT,
    S_DUMP
  } state_t;

  // Broadcast from the controller to every cell in the chain.
  typedef struct packed {
    cell_op_t          op;
    logic [CNT_W-1:0]  pos;
    logic [CNT_W-1:0]  count;
    logic              parity;
    logic [DATA_W-1:0] data;
  } cell_ctl_t;

endpackage

@@ src/bole_cell.sv @@
// One list position: holds a value and trades it with its neighbors.
// Depends on bole_pkg for the broadcast control word and widths.
module bole_cell (
  input  logic                       clk,
  input  logic [bole_pkg::CNT_W-1:0] idx,
  input  bole_pkg::cell_ctl_t        ctl,
  input  logic [bole_pkg::DATA_W-1:0] left_val,
  input  logic [bole_pkg::DATA_W-1:0] right_val,
  output logic [bole_pkg::DATA_W-1:0] val,
  output logic                       hit
);
  import bole_pkg::*;

  logic [DATA_W-1:0] val_r, val_nxt;
  logic              hit_r, hit_nxt;
  logic              is_left, is_right;

  // In a sort phase this cell pairs with its right or its left neighbor.
  assign is_left  = (idx[0] == ctl.parity) && ((idx + CNT_W'(1)) < ctl.count);
  assign is_right = (idx[0] != ctl.parity) && (idx != '0) && (idx < ctl.count);

  always_comb begin
    val_nxt = val_r;
    hit_nxt = hit_r;
    case (ctl.op)
      OP_INSERT: begin
        if (idx == ctl.pos) begin
          val_nxt = ctl.data;
        end else if (idx > ctl.pos) begin
          val_nxt = left_val;
        end
      end
      OP_DELETE: begin
        if (idx >= ctl.pos) begin
          val_nxt = right_val;
        end
      end
      OP_ROTATE: val_nxt = right_val;
      OP_COMPARE: hit_nxt = (val_r == ctl.data) && (idx < ctl.count);
      OP_SORT: begin
        // keep the smaller value on the left of each pair
        if (is_left && ($signed(right_val) < $signed(val_r))) begin
          val_nxt = right_val;
        end else if (is_right && ($signed(val_r) < $signed(left_val))) begin
          val_nxt = left_val;
        end
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    hit_r <= hit_nxt;
  end

  assign val = val_r;
  assign hit = hit_r;

endmodule

@@ src/bole_ctrl.sv @@
// Command sequencer: decodes commands, drives the cell chain, counts entries
// and registers result words. Depends on bole_pkg.
module bole_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   in_cmd,
  input  logic signed [31:0]           in_item_value,
  input  logic signed [31:0]           in_match_value,
  input  logic                         cfg_wr_en,
  input  logic [bole_pkg::LIMIT_W-1:0] cfg_wr_data,
  input  logic [bole_pkg::CAPACITY-1:0] hits,
  input  logic [bole_pkg::DATA_W-1:0]  head_val,
  output bole_pkg::cell_ctl_t          ctl,
  output logic                         out_valid,
  output logic signed [31:0]           out_entry_value,
  output logic [1:0]                   out_status,
  output logic                         out_last,
  output logic [4:0]                   out_entry_count,
  output logic                         out_is_full,
  output logic                         out_is_empty
);
  import bole_pkg::*;

  state_t            state_r, state_nxt;
  cmd_t              cmd_r;
  logic [DATA_W-1:0] item_r, match_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [LIMIT_W-1:0] limit_r;
  logic [IDX_W-1:0]  ctr_r, ctr_nxt;
  logic [CNT_W-1:0]  eff_lim;
  logic              full, empty, found, ctr_end;
  logic [IDX_W-1:0]  hit_pos;

  logic              emit;
  status_t           emit_status;
  logic [DATA_W-1:0] emit_value;
  logic              emit_last;

  logic              valid_r, last_r, is_full_r, is_empty_r;
  status_t           status_r;
  logic [DATA_W-1:0] value_r;
  logic [CNT_W-1:0]  ecount_r;

  assign eff_lim = (CNT_W'(limit_r) > CNT_W'(CAPACITY)) ? CNT_W'(CAPACITY) : CNT_W'(limit_r);
  assign full    = count_r >= eff_lim;
  assign empty   = (count_r == '0);
  assign found   = |hits;
  assign ctr_end = (ctr_r == IDX_W'(CAPACITY - 1));
  assign busy    = (state_r != S_IDLE);

  always_comb begin
    hit_pos = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (hits[i]) hit_pos = IDX_W'(i);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (start) state_nxt = S_DECODE;
      S_DECODE: begin
        state_nxt = S_IDLE;
        case (cmd_r)
          CMD_INS_AFTER: if (!empty && !full) state_nxt = S_FIND;
          CMD_DELETE:    if (!empty) state_nxt = S_FIND;
          CMD_SORT:      if (!empty) state_nxt = S_SORT;
          CMD_DUMP:      if (!empty) state_nxt = S_DUMP;
          default:       state_nxt = S_IDLE;
        endcase
      end
      S_FIND: state_nxt = S_IDLE;
      S_SORT: if (ctr_end) state_nxt = S_IDLE;
      S_DUMP: if (ctr_end) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // cell control, count update and result words
  always_comb begin
    ctl.op      = OP_HOLD;
    ctl.pos     = '0;
    ctl.count   = count_r;
    ctl.parity  = ctr_r[0];
    ctl.data    = item_r;
    count_nxt   = count_r;
    ctr_nxt     = ctr_r;
    emit        = 1'b0;
    emit_status = ST_OK;
    emit_value  = '0;
    emit_last   = 1'b1;
    case (state_r)
      S_DECODE: begin
        ctr_nxt = '0;
        emit    = 1'b1;
        case (cmd_r)
          CMD_INS_FRONT, CMD_INS_END: begin
            if (full) begin
              emit_status = ST_FULL;
            end else begin
              ctl.op    = OP_INSERT;
              ctl.pos   = (cmd_r == CMD_INS_FRONT) ? '0 : count_r;
              count_nxt = count_r + CNT_W'(1);
            end
          end
          CMD_INS_AFTER: begin
            if (empty) begin
              emit_status = ST_EMPTY;
            end else if (full) begin
              emit_status = ST_FULL;
            end else begin
              ctl.op   = OP_COMPARE;
              ctl.data = match_r;
              emit     = 1'b0;
            end
          end
          CMD_DELETE: begin
            if (empty) begin
              emit_status = ST_EMPTY;
            end else begin
              ctl.op   = OP_COMPARE;
              ctl.data = match_r;
              emit     = 1'b0;
            end
          end
          CMD_SORT, CMD_DUMP: begin
            if (empty) emit_status = ST_EMPTY;
            else emit = 1'b0;
          end
          default: emit_status = ST_OK;
        endcase
      end
      S_FIND: begin
        emit = 1'b1;
        if (!found) begin
          emit_status = ST_NOT_FOUND;
        end else if (cmd_r == CMD_INS_AFTER) begin
          ctl.op    = OP_INSERT;
          ctl.pos   = CNT_W'(hit_pos) + CNT_W'(1);
          count_nxt = count_r + CNT_W'(1);
        end else begin
          ctl.op    = OP_DELETE;
          ctl.pos   = CNT_W'(hit_pos);
          count_nxt = count_r - CNT_W'(1);
        end
      end
      S_SORT: begin
        ctl.op  = OP_SORT;
        ctr_nxt = ctr_r + IDX_W'(1);
        emit    = ctr_end;
      end
      S_DUMP: begin
        // rotate the whole ring once; the head cell shows each entry in turn
        ctl.op     = OP_ROTATE;
        ctr_nxt    = ctr_r + IDX_W'(1);
        emit       = CNT_W'(ctr_r) < count_r;
        emit_value = head_val;
        emit_last  = (CNT_W'(ctr_r) + CNT_W'(1)) == count_r;
      end
      default: ctl.op = OP_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      limit_r <= LIMIT_RESET;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      valid_r <= emit;
      if (cfg_wr_en) limit_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    ctr_r <= ctr_nxt;
    if (state_r == S_IDLE && start) begin
      cmd_r   <= cmd_t'(in_cmd);
      item_r  <= in_item_value;
      match_r <= in_match_value;
    end
    status_r   <= emit_status;
    value_r    <= emit_value;
    last_r     <= emit_last;
    ecount_r   <= count_nxt;
    is_full_r  <= count_nxt >= eff_lim;
    is_empty_r <= (count_nxt == '0);
  end

  assign out_valid       = valid_r;
  assign out_entry_value = value_r;
  assign out_status      = status_r;
  assign out_last        = last_r;
  assign out_entry_count = ecount_r;
  assign out_is_full     = is_full_r;
  assign out_is_empty    = is_empty_r;

endmodule

@@ src/bounded_ordered_list_engine_top.sv @@
// Bounded ordered list engine: top level with the chain of list cells.
// Depends on bole_pkg, bole_cell and bole_ctrl.
//
// Usage: drive in_cmd, in_item_value and in_match_value with start high; the
// word is taken at a clock edge where busy is low. Busy stays high until
// the command has finished and no new word is taken meanwhile.
// Results come out one word per cycle with out_valid high for that cycle
// only; out_last marks the final word of a command. The receiver cannot
// stall, so every word must be taken when shown.
// Insert front or end, unsupported codes and commands refused at decode
// give their result from the decode state; insert after and delete first
// run the per-cell compare, then pick the first match and shift.
// Sort runs CAPACITY odd-even exchange phases across the cells, then gives
// its result. Dump rotates the whole ring once, showing the head cell, so
// the entries come out in list order; busy stays high until the ring is
// back in place. cfg_wr_en/cfg_wr_data write the list limit while idle;
// the user must keep to this, as the block itself does not enforce it.
// Reset empties the list and sets the limit to 10; cell contents are not
// cleared and only entries below the count are ever shown.
module bounded_ordered_list_engine_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   in_cmd,
  input  logic signed [31:0]           in_item_value,
  input  logic signed [31:0]           in_match_value,
  input  logic                         cfg_wr_en,
  input  logic [bole_pkg::LIMIT_W-1:0] cfg_wr_data,
  output logic                         out_valid,
  output logic signed [31:0]           out_entry_value,
  output logic [1:0]                   out_status,
  output logic                         out_last,
  output logic [4:0]                   out_entry_count,
  output logic                         out_is_full,
  output logic                         out_is_empty
);
  import bole_pkg::*;

  cell_ctl_t         ctl;
  logic [DATA_W-1:0] cell_val [CAPACITY];
  logic [DATA_W-1:0] left_in  [CAPACITY];
  logic [DATA_W-1:0] right_in [CAPACITY];
  logic [CAPACITY-1:0] hits;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == 0) begin : g_first
        assign left_in[g] = '0;
      end else begin : g_mid
        assign left_in[g] = cell_val[g-1];
      end
      // the tail wraps to the head so a dump can rotate the ring
      if (g == CAPACITY - 1) begin : g_last
        assign right_in[g] = cell_val[0];
      end else begin : g_inner
        assign right_in[g] = cell_val[g+1];
      end

      bole_cell u_cell (
        .clk       (clk),
        .idx       (CNT_W'(g)),
        .ctl       (ctl),
        .left_val  (left_in[g]),
        .right_val (right_in[g]),
        .val       (cell_val[g]),
        .hit       (hits[g])
      );
    end
  endgenerate

  bole_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_item_value   (in_item_value),
    .in_match_value  (in_match_value),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .hits            (hits),
    .head_val        (cell_val[0]),
    .ctl             (ctl),
    .out_valid       (out_valid),
    .out_entry_value (out_entry_value),
    .out_status      (out_status),
    .out_last        (out_last),
    .out_entry_count (out_entry_count),
    .out_is_full     (out_is_full),
    .out_is_empty    (out_is_empty)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_dump_contig: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> out_valid)
    else $error("dump run broken before last word");

  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> out_is_full)
    else $error("full status without full flag");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_empty) |-> (out_entry_count == '0 && out_last))
    else $error("empty flag with nonzero count or open run");

endmodule
